FILE: design/ltd_pkg.sv
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared types and constants for the LZ77 triple decoder.
// ----------------------------------------------------------------------------
package ltd_pkg;

  localparam int TOKEN_FIELD_BITS = 16;
  localparam int BYTE_W           = 8;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One byte slot issued toward the write-back stage
  typedef struct packed {
    logic             valid;
    logic             last;      // slot carries the literal
    logic             in_range;  // distance reaches a written entry
    logic             use_last;  // distance one: take the byte written just before
    logic [BYTE_W-1:0] literal;
  } issue_t;

endpackage

FILE: design/ltd_ring_ram.sv
// ----------------------------------------------------------------------------
// ltd_ring_ram
// History ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ltd_ring_ram #(
  parameter int ADDR_W = 9
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [ltd_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [ltd_pkg::BYTE_W-1:0] rdata
);

  logic [ltd_pkg::BYTE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ltd_issue.sv
// ----------------------------------------------------------------------------
// ltd_issue
// Token sequencer: splits a token, walks its copy bytes and literal, and
// issues one ring read per copy byte.
// ----------------------------------------------------------------------------
module ltd_issue #(
  parameter int DISTANCE_BITS = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tok_valid,
  output logic                        tok_ready,
  input  logic [7:0]                  first_byte,
  input  logic [7:0]                  second_byte,
  input  logic [7:0]                  third_byte,
  input  logic                        advance,
  output ltd_pkg::issue_t             iss,
  output logic [DISTANCE_BITS-1:0]    iss_addr,
  output logic                        rd_en,
  output logic [DISTANCE_BITS-1:0]    rd_addr
);

  localparam int LEN_BITS = ltd_pkg::TOKEN_FIELD_BITS - DISTANCE_BITS;
  localparam int LEN_W    = (LEN_BITS > 0) ? LEN_BITS : 1;
  localparam logic [15:0] LEN_MASK = 16'((32'd1 << LEN_BITS) - 32'd1);
  localparam logic [DISTANCE_BITS:0] RING_SIZE = {1'b1, {DISTANCE_BITS{1'b0}}};

  ltd_pkg::state_t state, state_next;

  logic [DISTANCE_BITS-1:0] back_dist;
  logic [LEN_W-1:0]         len;
  logic [7:0]               lit;
  logic [LEN_W-1:0]         pos;
  logic [DISTANCE_BITS-1:0] wp;
  logic [DISTANCE_BITS:0]   fill;

  logic [15:0]              field;
  logic                     issue_go;
  logic                     is_last;
  logic                     accept;

  assign field    = {first_byte, second_byte};
  assign is_last  = (pos == len);
  assign issue_go = (state == ltd_pkg::ST_RUN) && advance;
  assign accept   = tok_valid && tok_ready;

  assign rd_en    = issue_go && !is_last;
  assign rd_addr  = wp - back_dist;
  assign iss_addr = wp;

  always_comb begin
    iss.valid    = issue_go;
    iss.last     = is_last;
    iss.in_range = !is_last && (back_dist != '0) && ({1'b0, back_dist} <= fill);
    iss.use_last = (back_dist == DISTANCE_BITS'(1));
    iss.literal  = lit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tok_ready  = 1'b0;
    unique case (state)
      ltd_pkg::ST_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          state_next = ltd_pkg::ST_RUN;
        end
      end
      ltd_pkg::ST_RUN: begin
        if (issue_go && is_last) begin
          state_next = ltd_pkg::ST_IDLE;
        end
      end
      default: state_next = ltd_pkg::ST_IDLE;
    endcase
  end

  // token fields
  always_ff @(posedge clk) begin
    if (accept) begin
      back_dist <= DISTANCE_BITS'(field >> LEN_BITS);
      len       <= LEN_W'(field & LEN_MASK);
      lit       <= third_byte;
    end
  end

  // ring position and fill count advance with each issued byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      wp   <= '0;
      fill <= '0;
    end else begin
      if (accept) begin
        pos <= '0;
      end else if (issue_go) begin
        pos <= pos + LEN_W'(1);
      end
      if (issue_go) begin
        wp <= wp + DISTANCE_BITS'(1);
        if (fill != RING_SIZE) begin
          fill <= fill + (DISTANCE_BITS+1)'(1);
        end
      end
    end
  end

endmodule

FILE: design/ltd_pack.sv
// ----------------------------------------------------------------------------
// ltd_pack
// Write-back stage: picks each output byte, writes it into the ring and
// packs bytes into results held in the output register.
// ----------------------------------------------------------------------------
module ltd_pack #(
  parameter int DISTANCE_BITS    = 9,
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ltd_pkg::issue_t                   iss,
  input  logic [DISTANCE_BITS-1:0]          iss_addr,
  input  logic [ltd_pkg::BYTE_W-1:0]        rdata,
  output logic                              advance,
  output logic                              mem_we,
  output logic [DISTANCE_BITS-1:0]          mem_waddr,
  output logic [ltd_pkg::BYTE_W-1:0]        mem_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [8*BYTES_PER_RESULT-1:0]     packed_bytes,
  output logic [$clog2(BYTES_PER_RESULT+1)-1:0] byte_count,
  output logic                              token_done
);

  localparam int PACK_W = 8 * BYTES_PER_RESULT;
  localparam int CNT_W  = $clog2(BYTES_PER_RESULT + 1);
  localparam int LANE_W = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

  ltd_pkg::issue_t          w;
  logic [DISTANCE_BITS-1:0] w_addr;
  logic [7:0]               last_byte;
  logic [PACK_W-1:0]        acc;
  logic [LANE_W-1:0]        lane;

  logic [7:0]               cur_byte;
  logic [PACK_W-1:0]        acc_next;
  logic                     flush;

  assign advance = !out_valid || out_ready;

  always_comb begin
    if (w.last) begin
      cur_byte = w.literal;
    end else if (!w.in_range) begin
      cur_byte = '0;
    end else if (w.use_last) begin
      cur_byte = last_byte;
    end else begin
      cur_byte = rdata;
    end
  end

  always_comb begin
    acc_next = acc;
    acc_next[lane*8 +: 8] = cur_byte;
  end

  assign flush     = w.last || (lane == LANE_W'(BYTES_PER_RESULT - 1));
  assign mem_we    = w.valid && advance;
  assign mem_waddr = w_addr;
  assign mem_wdata = cur_byte;

  // write-back stage register; hold while the output register is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else if (advance) begin
      w <= iss;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      w_addr <= iss_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte <= '0;
      acc       <= '0;
      lane      <= '0;
    end else if (mem_we) begin
      last_byte <= cur_byte;
      if (flush) begin
        acc  <= '0;
        lane <= '0;
      end else begin
        acc  <= acc_next;
        lane <= lane + LANE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mem_we && flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && flush) begin
      packed_bytes <= acc_next;
      byte_count   <= CNT_W'(lane) + CNT_W'(1);
      token_done   <= w.last;
    end
  end

endmodule

FILE: design/lz77_triple_decoder_core.sv
// ----------------------------------------------------------------------------
// lz77_triple_decoder_core
// LZ77 token decoder: expands each 3-byte token into copied history bytes
// and a literal, packed several bytes per output transaction.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tlast
//  s_axis  | in  | first_byte, second_byte, third_byte     | -
//  m_axis  | out | packed_bytes, byte_count, zero padding  | token_done
//
//  A token is accepted in the idle state, then takes one cycle per copied byte
//  and one for the literal while the output register is not blocked, set by
//  the single-byte ring port. Bytes pass the write-back and output registers.
//  After reset the ring reads as zero through a fill count; no clear pass.
//  m_tready low with a result waiting holds write-back and the byte sequencer.
// ----------------------------------------------------------------------------
module lz77_triple_decoder_core #(
  parameter int DISTANCE_BITS    = 9,
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [8*B-1:0] packed_bytes, then byte_count, then zero fill (B = BYTES_PER_RESULT)
  output logic [((8*BYTES_PER_RESULT + $clog2(BYTES_PER_RESULT+1) + 7) / 8) * 8 - 1:0] m_tdata,
  output logic        m_tlast
);

  localparam int PACK_W = 8 * BYTES_PER_RESULT;
  localparam int CNT_W  = $clog2(BYTES_PER_RESULT + 1);
  localparam int DATA_W = ((PACK_W + CNT_W + 7) / 8) * 8;

  ltd_pkg::issue_t          iss;
  logic [DISTANCE_BITS-1:0] iss_addr;
  logic                     rd_en;
  logic [DISTANCE_BITS-1:0] rd_addr;
  logic [7:0]               rdata;
  logic                     advance;
  logic                     mem_we;
  logic [DISTANCE_BITS-1:0] mem_waddr;
  logic [7:0]               mem_wdata;
  logic [PACK_W-1:0]        packed_bytes;
  logic [CNT_W-1:0]         byte_count;

  ltd_issue #(
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_issue (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (s_tvalid),
    .tok_ready  (s_tready),
    .first_byte (s_tdata[7:0]),
    .second_byte(s_tdata[15:8]),
    .third_byte (s_tdata[23:16]),
    .advance    (advance),
    .iss        (iss),
    .iss_addr   (iss_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  ltd_ring_ram #(
    .ADDR_W(DISTANCE_BITS)
  ) u_ring (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  ltd_pack #(
    .DISTANCE_BITS   (DISTANCE_BITS),
    .BYTES_PER_RESULT(BYTES_PER_RESULT)
  ) u_pack (
    .clk         (clk),
    .rst         (rst),
    .iss         (iss),
    .iss_addr    (iss_addr),
    .rdata       (rdata),
    .advance     (advance),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .packed_bytes(packed_bytes),
    .byte_count  (byte_count),
    .token_done  (m_tlast)
  );

  assign m_tdata = DATA_W'({byte_count, packed_bytes});

endmodule

FILE: design/ltd_checker.sv
// ----------------------------------------------------------------------------
// ltd_checker
// Port-level checks for the LZ77 triple decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ltd_checker #(
  parameter int BYTES_PER_RESULT = 4
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [((8*BYTES_PER_RESULT + $clog2(BYTES_PER_RESULT+1) + 7) / 8) * 8 - 1:0] m_tdata,
  input logic        m_tlast
);

  localparam int PACK_W = 8 * BYTES_PER_RESULT;
  localparam int CNT_W  = $clog2(BYTES_PER_RESULT + 1);

  logic [CNT_W-1:0] cnt;
  assign cnt = m_tdata[PACK_W +: CNT_W];

  // one token at a time: input closes right after an accepted transaction
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a token was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output transaction changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cnt != '0) && (cnt <= CNT_W'(BYTES_PER_RESULT)))
    else $error("byte count out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> cnt == CNT_W'(BYTES_PER_RESULT))
    else $error("partial result without token end");

endmodule

bind lz77_triple_decoder_core ltd_checker #(
  .BYTES_PER_RESULT(BYTES_PER_RESULT)
) u_ltd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

FILE: dv/lz77_decode_checker.sv
// ----------------------------------------------------------------------------
// lz77_decode_checker
// Watches both stream channels of the LZ77 triple decoder. It expands every
// accepted token against its own copy of the history ring and compares each
// output transaction, field by field, with the oldest expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lz77_decode_checker #(
  parameter int M_W = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tready,
  input  logic [23:0]    s_tdata,
  input  logic           m_tvalid,
  input  logic           m_tready,
  input  logic [M_W-1:0] m_tdata,
  input  logic           m_tlast,
  output int             fail_count,
  output int             pending,
  output int             tokens_seen,
  output int             words_seen
);

  localparam int DIST_W    = 9;
  localparam int RING_SIZE = 1 << DIST_W;
  localparam int LANES     = 4;
  localparam int BW        = ltd_pkg::BYTE_W;

  typedef struct packed {
    logic [LANES*BW-1:0] packed_bytes;
    logic [2:0]          byte_count;
    logic                token_done;
  } out_word_t;

  logic [BW-1:0]     history [RING_SIZE];
  logic [DIST_W-1:0] wr_ptr;
  out_word_t         expected_words[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    tokens_seen = 0;
    words_seen  = 0;
  end

  // Expand one token into the output words it must produce.
  task automatic expand_token(input logic [23:0] tok);
    logic [DIST_W-1:0]      back_dist;
    logic [DIST_W-1:0]      rd_addr;
    logic [BW-1:0]          lit;
    logic [BW-1:0]          b;
    logic [LANES*BW-1:0]    acc;
    int                     copy_len;
    int                     lane;
    out_word_t              w;
    back_dist = {tok[7:0], tok[15]};
    copy_len  = int'(tok[14:8]);
    lit       = tok[23:16];
    acc       = '0;
    lane      = 0;
    for (int i = 0; i <= copy_len; i++) begin
      if (i < copy_len) begin
        rd_addr = wr_ptr - back_dist;
        b = (back_dist == '0) ? '0 : history[rd_addr];
      end else begin
        b = lit;
      end
      // write back at once so overlapping copies see this byte
      history[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      acc[BW*lane +: BW] = b;
      lane++;
      if (lane == LANES || i == copy_len) begin
        w.packed_bytes = acc;
        w.byte_count   = 3'(lane);
        w.token_done   = (i == copy_len);
        expected_words.insert(expected_words.size(), w);
        acc  = '0;
        lane = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RING_SIZE; k++) history[k] = '0;
      wr_ptr = '0;
      expected_words.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_token(s_tdata);
        tokens_seen++;
      end
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("output transaction with no expected word: tdata %h tlast %b",
                 m_tdata, m_tlast);
          fail_count++;
        end else begin
          out_word_t w;
          w = expected_words.pop_front();
          if (m_tdata[LANES*BW-1:0] !== w.packed_bytes) begin
            $error("packed_bytes mismatch: expected %h, actual %h",
                   w.packed_bytes, m_tdata[LANES*BW-1:0]);
            fail_count++;
          end
          if (m_tdata[LANES*BW +: 3] !== w.byte_count) begin
            $error("byte_count mismatch: expected %0d, actual %0d",
                   w.byte_count, m_tdata[LANES*BW +: 3]);
            fail_count++;
          end
          if (m_tlast !== w.token_done) begin
            $error("token_done mismatch: expected %b, actual %b",
                   w.token_done, m_tlast);
            fail_count++;
          end
        end
      end
      pending <= expected_words.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the LZ77 triple decoder: a directed set of tokens at the
// field extremes and special distances, then random tokens, with random
// idling on both channels and one long sink hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int M_W        = ((8*4 + $clog2(4+1) + 7) / 8) * 8;
  localparam int N_RANDOM   = 410;
  localparam int QUIET_LEN  = 60;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_WAIT  = 16;
  localparam int MAX_CYCLES = 1_000_000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [23:0]    s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;
  logic           m_tlast;

  int fail_count;
  int pending;
  int tokens_seen;
  int words_seen;
  int cycle_count = 0;
  int token_idx = 0;
  bit quiet_tail = 1'b0;
  bit hold_off_req = 1'b0;

  always #2 clk = ~clk;

  lz77_triple_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  lz77_decode_checker #(.M_W(M_W)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .tokens_seen (tokens_seen),
    .words_seen  (words_seen)
  );

  function automatic logic [23:0] make_token(input logic [8:0] back_dist,
                                             input logic [6:0] len,
                                             input logic [7:0] lit);
    return {lit, back_dist[0], len, back_dist[8:1]};
  endfunction

  // Offer one token and hold it until the transaction completes.
  task automatic send_token(input logic [23:0] tok);
    if (!quiet_tail && (token_idx / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tok;
    do @(posedge clk); while (!s_tready);
    token_idx++;
  endtask

  function automatic logic [23:0] random_token();
    logic [8:0] back_dist;
    logic [6:0] len;
    int         kind;
    kind      = $urandom_range(0, 9);
    back_dist = 9'($urandom_range(1, 511));
    len       = 7'($urandom_range(0, 20));
    if (kind <= 4) begin
      back_dist = 9'($urandom_range(1, 16));
      len       = 7'($urandom_range(0, 12));
    end else if (kind == 7) begin
      return 24'($urandom);
    end else if (kind == 8) begin
      len = '0;
    end else if (kind == 9) begin
      len = 7'($urandom_range(100, 127));
    end
    return make_token(back_dist, len, 8'($urandom));
  endfunction

  // Sink: random ready bursts, one long hold-off on request, steady at the end.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        n = quiet_tail ? 1 : $urandom_range(1, 24);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("lz77_triple_decoder_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed tokens
    send_token(make_token(9'd0,   7'd0,   8'h00));  // all fields at zero
    send_token(make_token(9'd300, 7'd6,   8'hA5));  // reaches before the first byte
    send_token(make_token(9'd511, 7'd3,   8'h5A));
    send_token(make_token(9'd1,   7'd9,   8'h3C));  // overlap: repeat last byte
    send_token(make_token(9'd2,   7'd7,   8'hC3));
    send_token(make_token(9'd0,   7'd4,   8'h77));  // zero distance, copy zeros
    send_token(make_token(9'd0,   7'd0,   8'hFF));  // literal only
    send_token(make_token(9'd8,   7'd2,   8'h11));  // three bytes
    send_token(make_token(9'd8,   7'd3,   8'h22));  // exactly one full word
    send_token(make_token(9'd8,   7'd4,   8'h33));  // one byte spills over
    send_token(make_token(9'd3,   7'd1,   8'h44));
    send_token(make_token(9'd5,   7'd127, 8'h81));  // longest copy
    send_token(24'hFFFFFF);                          // every bit set
    send_token(make_token(9'd511, 7'd40,  8'h96));  // before the ring wraps: reaches past written bytes
    send_token(make_token(9'd256, 7'd10,  8'h69));
    send_token(make_token(9'd1,   7'd0,   8'h00));
    send_token(make_token(9'd4,   7'd5,   8'hF0));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 120) hold_off_req = 1'b1;
      quiet_tail = (i >= N_RANDOM - QUIET_LEN);
      send_token(random_token());
    end
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("run covered %0d tokens and %0d output words, with idling on both sides",
             tokens_seen, words_seen);
    $display("and a %0d-cycle sink hold-off; %0d mismatches", HOLD_LEN, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("lz77_triple_decoder_core regression: pass");
    end else begin
      $display("lz77_triple_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
